[rtl/assert_macros.svh]
// Assertion macros of the touch gesture detector, included by its top-level core file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define TGD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TGD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tgd_pkg.sv]
// Types, codes and reset constants of the touch gesture detector.
package tgd_pkg;

  // Phase codes of the gesture state machine
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_PRESSED  = 2'd2;
  localparam logic [1:0] PH_LONG     = 2'd3;

  // Reset values of the timing registers
  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd30;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd500;
  localparam logic [15:0] REPEAT_MS_RST     = 16'd200;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_REPEAT     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    GEST_PRESS       = 3'd0,
    GEST_CLICK       = 3'd1,
    GEST_LONG_START  = 3'd2,
    GEST_LONG_REPEAT = 3'd3,
    GEST_LONG_END    = 3'd4
  } gesture_e;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic               touch_down;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    gesture_e           gesture_code;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic [31:0]        held_ms;
    logic [31:0]        stamp_ms;
  } gesture_t;

endpackage

[rtl/tgd_cfg_regs.sv]
// Timing registers of the touch gesture detector, written over the config channel.
module tgd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [tgd_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [15:0]                    wr_data_i,
  output tgd_pkg::cfg_t                  cfg_o
);
  import tgd_pkg::*;

  cfg_t cfg_d, cfg_q;

  // Decode the write; an unknown index leaves all registers alone
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_DEBOUNCE:   cfg_d.debounce_ms   = wr_data_i;
        CFG_LONG_PRESS: cfg_d.long_press_ms = wr_data_i;
        CFG_REPEAT:     cfg_d.repeat_ms     = wr_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg_q.long_press_ms <= LONG_PRESS_MS_RST;
      cfg_q.repeat_ms     <= REPEAT_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/tgd_engine.sv]
// Gesture state machine: touch state registers and per-sample event decision.
module tgd_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  tgd_pkg::sample_t  sample_i,
  input  tgd_pkg::cfg_t     cfg_i,
  output logic              evt_valid_o,
  output tgd_pkg::gesture_t evt_o
);
  import tgd_pkg::*;

  logic [1:0]         phase_d, phase_q;
  logic signed [15:0] origin_x_d, origin_x_q;
  logic signed [15:0] origin_y_d, origin_y_q;
  logic signed [15:0] recent_x_d, recent_x_q;
  logic signed [15:0] recent_y_d, recent_y_q;
  logic [31:0]        start_ms_d, start_ms_q;
  logic [31:0]        repeat_ms_d, repeat_ms_q;

  logic [31:0] held_ms;
  logic [31:0] since_repeat_ms;
  gesture_e    code;

  // Elapsed times wrap modulo 2^32
  assign held_ms         = sample_i.now_ms - start_ms_q;
  assign since_repeat_ms = sample_i.now_ms - repeat_ms_q;

  // Next state and event for the sample at hand
  always_comb begin
    phase_d     = phase_q;
    origin_x_d  = origin_x_q;
    origin_y_d  = origin_y_q;
    start_ms_d  = start_ms_q;
    repeat_ms_d = repeat_ms_q;
    evt_valid_o = 1'b0;
    code        = GEST_PRESS;

    // Track the last touched point; released samples do not move it
    recent_x_d = sample_i.touch_down ? sample_i.pos_x : recent_x_q;
    recent_y_d = sample_i.touch_down ? sample_i.pos_y : recent_y_q;

    unique case (phase_q)
      PH_IDLE: begin
        if (sample_i.touch_down) begin
          origin_x_d = sample_i.pos_x;
          origin_y_d = sample_i.pos_y;
          start_ms_d = sample_i.now_ms;
          phase_d    = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (!sample_i.touch_down) begin
          phase_d = PH_IDLE;
        end else if (held_ms >= {16'd0, cfg_i.debounce_ms}) begin
          phase_d     = PH_PRESSED;
          evt_valid_o = 1'b1;
          code        = GEST_PRESS;
        end
      end
      PH_PRESSED: begin
        if (!sample_i.touch_down) begin
          phase_d     = PH_IDLE;
          evt_valid_o = 1'b1;
          code        = GEST_CLICK;
        end else if (held_ms >= {16'd0, cfg_i.long_press_ms}) begin
          repeat_ms_d = sample_i.now_ms;
          phase_d     = PH_LONG;
          evt_valid_o = 1'b1;
          code        = GEST_LONG_START;
        end
      end
      PH_LONG: begin
        if (!sample_i.touch_down) begin
          phase_d     = PH_IDLE;
          evt_valid_o = 1'b1;
          code        = GEST_LONG_END;
        end else if (since_repeat_ms >= {16'd0, cfg_i.repeat_ms}) begin
          repeat_ms_d = sample_i.now_ms;
          evt_valid_o = 1'b1;
          code        = GEST_LONG_REPEAT;
        end
      end
    endcase
  end

  // Assemble the event payload; the last point already includes this sample
  always_comb begin
    evt_o.gesture_code = code;
    evt_o.first_x      = origin_x_q;
    evt_o.first_y      = origin_y_q;
    evt_o.last_x       = recent_x_d;
    evt_o.last_y       = recent_y_d;
    evt_o.held_ms      = held_ms;
    evt_o.stamp_ms     = sample_i.now_ms;
  end

  // Commit state only when the sample is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      recent_x_q  <= '0;
      recent_y_q  <= '0;
      start_ms_q  <= '0;
      repeat_ms_q <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      origin_x_q  <= origin_x_d;
      origin_y_q  <= origin_y_d;
      recent_x_q  <= recent_x_d;
      recent_y_q  <= recent_y_d;
      start_ms_q  <= start_ms_d;
      repeat_ms_q <= repeat_ms_d;
    end
  end

endmodule

[rtl/touch_gesture_detector_core.sv]
// Top level of the touch gesture detector: sample register, timing registers, engine, event register.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    tuser touch_down, tdata x,y,now
//   m_axis    out        m_axis_tvalid/m_axis_tready    tuser gesture code, tdata event
//   cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One sample per cycle is accepted unless the event register stalls; the sample register
// is loaded on acceptance, and its event, if any, enters the event register on consumption.
// Reset clears the gesture state to idle and the timing registers to 30/500/200 ms.
// A stalled event register holds the sample register, which then holds the input.
// Config writes are registered and always accepted.
module touch_gesture_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // pos_x, pos_y, now_ms
  input  logic [0:0]                    s_axis_tuser,  // touch_down
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // first_x, first_y, last_x, last_y, held_ms, stamp_ms
  output logic [127:0]                  m_axis_tdata,
  output logic [2:0]                    m_axis_tuser,  // gesture_code
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tgd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import tgd_pkg::*;

  cfg_t     cfg;
  sample_t  smp_q;
  logic     smp_valid_q;
  gesture_t evt;
  logic     evt_valid;
  gesture_t res_q;
  logic     res_valid_q;
  logic     res_free;
  logic     advance;

  // Timing registers
  assign cfg_ready_o = 1'b1;

  tgd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Consume the held sample whenever the event register can take a result
  assign res_free      = !res_valid_q || m_axis_tready;
  assign advance       = smp_valid_q && res_free;
  assign s_axis_tready = !smp_valid_q || res_free;

  // Sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      smp_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      smp_q.touch_down <= s_axis_tuser[0];
      smp_q.pos_x      <= s_axis_tdata[15:0];
      smp_q.pos_y      <= s_axis_tdata[31:16];
      smp_q.now_ms     <= s_axis_tdata[63:32];
    end
  end

  tgd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .sample_i    (smp_q),
    .cfg_i       (cfg),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  // Event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= advance && evt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && evt_valid) begin
      res_q <= evt;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = res_q.gesture_code;
  assign m_axis_tdata  = {res_q.stamp_ms, res_q.held_ms, res_q.last_y, res_q.last_x,
                          res_q.first_y, res_q.first_x};

  // Checks
`include "assert_macros.svh"

  `TGD_ASSERT(a_stall_cause, clk_i, rst_ni, !s_axis_tready |-> smp_valid_q && m_axis_tvalid && !m_axis_tready, "input stalled without a blocked event")
  `TGD_ASSERT(a_event_source, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(advance && evt_valid), "event appeared without a consumed sample")
  `TGD_ASSERT(a_event_stamp, clk_i, rst_ni, advance && evt_valid |=> m_axis_tdata[127:96] == $past(smp_q.now_ms), "event stamp differs from sample time")

endmodule
